>>> hdl/jkm_pkg.sv
// ----------------------------------------------------------------------------
// jkm_pkg
// Shared types, character codes and name matchers for the key message parser.
// ----------------------------------------------------------------------------
package jkm_pkg;

	// characters of the grammar
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LC_C   = 8'h63;
	localparam logic [7:0] CH_LC_D   = 8'h64;
	localparam logic [7:0] CH_LC_E   = 8'h65;
	localparam logic [7:0] CH_LC_K   = 8'h6B;
	localparam logic [7:0] CH_LC_O   = 8'h6F;
	localparam logic [7:0] CH_LC_P   = 8'h70;
	localparam logic [7:0] CH_LC_Y   = 8'h79;

	// largest code that is accepted
	localparam logic [8:0] CODE_MAX = 9'h0FF;
	localparam logic [8:0] CODE_SAT = 9'h100;

	// member name matcher codes
	localparam logic [3:0] NM_START     = 4'd0;
	localparam logic [3:0] NM_O         = 4'd1;
	localparam logic [3:0] NM_OP        = 4'd2;
	localparam logic [3:0] NM_C         = 4'd3;
	localparam logic [3:0] NM_CO        = 4'd4;
	localparam logic [3:0] NM_COD       = 4'd5;
	localparam logic [3:0] NM_CODE      = 4'd6;
	localparam logic [3:0] NM_OTHER     = 4'd7;
	localparam logic [3:0] NM_OP_DONE   = 4'd8;
	localparam logic [3:0] NM_CODE_DONE = 4'd9;

	// op value matcher codes
	localparam logic [2:0] VM_START    = 3'd0;
	localparam logic [2:0] VM_K        = 3'd1;
	localparam logic [2:0] VM_KE       = 3'd2;
	localparam logic [2:0] VM_KEY      = 3'd3;
	localparam logic [2:0] VM_OTHER    = 3'd4;
	localparam logic [2:0] VM_KEY_DONE = 3'd5;

	// one input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
		logic       end_without_byte;
	} beat_t;

	// outcome of one parser step
	typedef struct packed {
		logic       ends;
		logic       key_valid;
		logic [7:0] key_code;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic [3:0] name_step(input logic [3:0] s, input logic [7:0] c);
		logic [3:0] r;
		r = NM_OTHER;
		if (s >= NM_OTHER) begin
			r = s;
		end else if (c == CH_NUL) begin
			if (s == NM_OP)
				r = NM_OP_DONE;
			else if (s == NM_CODE)
				r = NM_CODE_DONE;
		end else begin
			case (s)
				NM_START: begin
					if (c == CH_LC_O)
						r = NM_O;
					else if (c == CH_LC_C)
						r = NM_C;
				end
				NM_O:   if (c == CH_LC_P) r = NM_OP;
				NM_C:   if (c == CH_LC_O) r = NM_CO;
				NM_CO:  if (c == CH_LC_D) r = NM_COD;
				NM_COD: if (c == CH_LC_E) r = NM_CODE;
				default: r = NM_OTHER;
			endcase
		end
		return r;
	endfunction

	function automatic logic [3:0] name_close(input logic [3:0] s);
		logic [3:0] r;
		r = NM_OTHER;
		if (s == NM_OP || s == NM_OP_DONE)
			r = NM_OP_DONE;
		else if (s == NM_CODE || s == NM_CODE_DONE)
			r = NM_CODE_DONE;
		return r;
	endfunction

	function automatic logic [2:0] value_step(input logic [2:0] s, input logic [7:0] c);
		logic [2:0] r;
		r = VM_OTHER;
		if (s >= VM_OTHER) begin
			r = s;
		end else if (c == CH_NUL) begin
			if (s == VM_KEY)
				r = VM_KEY_DONE;
		end else begin
			case (s)
				VM_START: if (c == CH_LC_K) r = VM_K;
				VM_K:     if (c == CH_LC_E) r = VM_KE;
				VM_KE:    if (c == CH_LC_Y) r = VM_KEY;
				default:  r = VM_OTHER;
			endcase
		end
		return r;
	endfunction

endpackage

>>> hdl/json_key_message_parser.sv
// The final byte beat passes the input register and loads the result register.
// Throughput: one byte beat per cycle; the parser state updates once per byte.
// A result waiting in the output register holds up only a following final byte.
// Reset (arst_n low, asynchronous) empties both registers and puts the parser
// back at the opening brace; after each result the parser returns there too.
// ----------------------------------------------------------------------------
// json_key_message_parser
// Streaming checker for a flat key message object, one byte per beat.
// ----------------------------------------------------------------------------
module json_key_message_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	input  logic       end_without_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       key_valid,
	output logic [7:0] key_code
);

	jkm_pkg::beat_t   beat;
	jkm_pkg::beat_t   beat_s1;
	jkm_pkg::result_t result;
	logic             valid_s1;
	logic             out_ready;
	logic             consume;

	assign beat.text_byte        = text_byte;
	assign beat.last_byte        = last_byte;
	assign beat.end_without_byte = end_without_byte;

	// a held beat moves on unless it ends a message and the result slot is full
	assign consume = valid_s1 && (!result.ends || out_ready);

	jkm_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.beat       (beat),
		.consume    (consume),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	jkm_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.consume (consume),
		.result  (result)
	);

	jkm_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (consume && result.ends),
		.result       (result),
		.ready        (out_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.key_valid    (key_valid),
		.key_code     (key_code)
	);

endmodule

>>> hdl/jkm_in_stage.sv
// ----------------------------------------------------------------------------
// jkm_in_stage
// Input register: holds one beat until the parser consumes it.
// ----------------------------------------------------------------------------
module jkm_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  jkm_pkg::beat_t beat,
	input  logic          consume,
	output logic          valid_s1,
	output jkm_pkg::beat_t beat_s1
);

	logic valid_q;

	// stall only while a held beat cannot move on
	assign item_stall = valid_q && !consume;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!item_stall)
			valid_q <= item_valid;
	end

	// payload
	always_ff @(posedge clk) begin
		if (!item_stall && item_valid)
			beat_s1 <= beat;
	end

	assign valid_s1 = valid_q;

endmodule

>>> hdl/jkm_parse.sv
// ----------------------------------------------------------------------------
// jkm_parse
// Parser state registers and the one-byte step of the grammar.
// ----------------------------------------------------------------------------
module jkm_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  jkm_pkg::beat_t   beat_s1,
	input  logic             consume,
	output jkm_pkg::result_t result
);

	// grammar phases
	localparam logic [3:0] PH_OPEN    = 4'd0;
	localparam logic [3:0] PH_MEMBER  = 4'd1;
	localparam logic [3:0] PH_NAME    = 4'd2;
	localparam logic [3:0] PH_COLON   = 4'd3;
	localparam logic [3:0] PH_VALUE   = 4'd4;
	localparam logic [3:0] PH_OPSTR   = 4'd5;
	localparam logic [3:0] PH_SKIPSTR = 4'd6;
	localparam logic [3:0] PH_SIGN    = 4'd7;
	localparam logic [3:0] PH_DIGITS  = 4'd8;
	localparam logic [3:0] PH_AFTER   = 4'd9;
	localparam logic [3:0] PH_TRAIL   = 4'd10;
	localparam logic [3:0] PH_FAIL    = 4'd11;

	logic [3:0] phase_q, phase_d;
	logic [3:0] name_q, name_d;
	logic [2:0] value_q, value_d;
	logic       esc_q, esc_d;
	logic       neg_q, neg_d;
	logic [8:0] code_q, code_d;
	logic       seen_code_q, seen_code_d;
	logic       seen_op_q, seen_op_d;
	logic       op_key_q, op_key_d;

	logic [7:0]  c;
	logic        str_content;
	logic        str_close;
	logic        code_member;
	logic [11:0] code_next;
	logic        ok;

	// phase after a value has ended
	function automatic logic [3:0] after_phase(input logic [3:0] cur, input logic [7:0] ch);
		logic [3:0] r;
		r = PH_FAIL;
		if (jkm_pkg::is_ws(ch))
			r = cur;
		else if (ch == jkm_pkg::CH_COMMA)
			r = PH_MEMBER;
		else if (ch == jkm_pkg::CH_RBRACE)
			r = PH_TRAIL;
		return r;
	endfunction

	assign c           = beat_s1.text_byte;
	assign code_member = (name_q == jkm_pkg::NM_CODE_DONE);

	// string byte class and escape tracking
	always_comb begin
		str_content = 1'b0;
		str_close   = 1'b0;
		esc_d       = esc_q;
		if (esc_q) begin
			esc_d       = 1'b0;
			str_content = 1'b1;
		end else if (c == jkm_pkg::CH_BSLASH) begin
			esc_d = 1'b1;
		end else if (c == jkm_pkg::CH_QUOTE) begin
			str_close = 1'b1;
		end else begin
			str_content = 1'b1;
		end
	end

	// code times ten plus the new digit
	assign code_next = {code_q, 3'b000} + {2'b00, code_q, 1'b0} + {8'h00, c[3:0]};

	// one grammar step, then the end-of-message check
	always_comb begin
		phase_d     = phase_q;
		name_d      = name_q;
		value_d     = value_q;
		neg_d       = neg_q;
		code_d      = code_q;
		seen_code_d = seen_code_q;
		seen_op_d   = seen_op_q;
		op_key_d    = op_key_q;
		if (!beat_s1.end_without_byte) begin
			case (phase_q)
				PH_OPEN: begin
					if (!jkm_pkg::is_ws(c))
						phase_d = (c == jkm_pkg::CH_LBRACE) ? PH_MEMBER : PH_FAIL;
				end
				PH_MEMBER: begin
					if (!jkm_pkg::is_ws(c)) begin
						if (c == jkm_pkg::CH_RBRACE) begin
							phase_d = PH_TRAIL;
						end else if (c == jkm_pkg::CH_QUOTE) begin
							phase_d = PH_NAME;
							name_d  = jkm_pkg::NM_START;
						end else begin
							phase_d = PH_FAIL;
						end
					end
				end
				PH_NAME: begin
					if (str_content) begin
						name_d = jkm_pkg::name_step(name_q, c);
					end else if (str_close) begin
						name_d  = jkm_pkg::name_close(name_q);
						phase_d = PH_COLON;
					end
				end
				PH_COLON: begin
					if (!jkm_pkg::is_ws(c))
						phase_d = (c == jkm_pkg::CH_COLON) ? PH_VALUE : PH_FAIL;
				end
				PH_VALUE: begin
					if (!jkm_pkg::is_ws(c)) begin
						if (name_q == jkm_pkg::NM_OP_DONE) begin
							if (c == jkm_pkg::CH_QUOTE) begin
								phase_d = PH_OPSTR;
								value_d = jkm_pkg::VM_START;
							end else begin
								phase_d = PH_FAIL;
							end
						end else begin
							if (code_member) begin
								neg_d  = 1'b0;
								code_d = '0;
							end
							if (c == jkm_pkg::CH_MINUS) begin
								if (code_member)
									neg_d = 1'b1;
								phase_d = PH_SIGN;
							end else if (jkm_pkg::is_digit(c)) begin
								if (code_member) begin
									code_d      = {5'b00000, c[3:0]};
									seen_code_d = 1'b1;
								end
								phase_d = PH_DIGITS;
							end else if (c == jkm_pkg::CH_QUOTE && !code_member) begin
								phase_d = PH_SKIPSTR;
							end else begin
								phase_d = PH_FAIL;
							end
						end
					end
				end
				PH_OPSTR: begin
					if (str_content) begin
						value_d = jkm_pkg::value_step(value_q, c);
					end else if (str_close) begin
						seen_op_d = 1'b1;
						op_key_d  = (value_q == jkm_pkg::VM_KEY) ||
							(value_q == jkm_pkg::VM_KEY_DONE);
						phase_d   = PH_AFTER;
					end
				end
				PH_SKIPSTR: begin
					if (str_close)
						phase_d = PH_AFTER;
				end
				PH_SIGN: begin
					if (jkm_pkg::is_digit(c)) begin
						if (code_member) begin
							code_d      = {5'b00000, c[3:0]};
							seen_code_d = 1'b1;
						end
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_FAIL;
					end
				end
				PH_DIGITS: begin
					if (jkm_pkg::is_digit(c)) begin
						if (code_member) begin
							if (code_q[8] || code_next > {3'b000, jkm_pkg::CODE_MAX})
								code_d = jkm_pkg::CODE_SAT;
							else
								code_d = code_next[8:0];
						end
					end else begin
						phase_d = after_phase(PH_AFTER, c);
					end
				end
				PH_AFTER: phase_d = after_phase(PH_AFTER, c);
				PH_TRAIL: begin
					if (!jkm_pkg::is_ws(c))
						phase_d = PH_FAIL;
				end
				default: phase_d = PH_FAIL;
			endcase
		end

		// acceptance of the finished message
		ok = (phase_d == PH_TRAIL) && seen_code_d && (!seen_op_d || op_key_d) &&
			(code_d <= jkm_pkg::CODE_MAX) && !(neg_d && (code_d != '0));
		result.ends      = beat_s1.last_byte || beat_s1.end_without_byte;
		result.key_valid = ok;
		result.key_code  = ok ? code_d[7:0] : 8'h00;
	end

	// state registers, back to reset values after a message ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			name_q      <= jkm_pkg::NM_START;
			value_q     <= jkm_pkg::VM_START;
			esc_q       <= 1'b0;
			neg_q       <= 1'b0;
			code_q      <= '0;
			seen_code_q <= 1'b0;
			seen_op_q   <= 1'b0;
			op_key_q    <= 1'b0;
		end else if (consume) begin
			if (result.ends) begin
				phase_q     <= PH_OPEN;
				name_q      <= jkm_pkg::NM_START;
				value_q     <= jkm_pkg::VM_START;
				esc_q       <= 1'b0;
				neg_q       <= 1'b0;
				code_q      <= '0;
				seen_code_q <= 1'b0;
				seen_op_q   <= 1'b0;
				op_key_q    <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				name_q      <= name_d;
				value_q     <= value_d;
				neg_q       <= neg_d;
				code_q      <= code_d;
				seen_code_q <= seen_code_d;
				seen_op_q   <= seen_op_d;
				op_key_q    <= op_key_d;
				// escape state only matters inside strings; clear it on each opening quote
				if (phase_d != phase_q && (phase_d == PH_NAME || phase_d == PH_OPSTR ||
					phase_d == PH_SKIPSTR))
					esc_q <= 1'b0;
				else if (phase_q == PH_NAME || phase_q == PH_OPSTR ||
					phase_q == PH_SKIPSTR)
					esc_q <= esc_d;
			end
		end
	end

endmodule

>>> hdl/jkm_out_reg.sv
// ----------------------------------------------------------------------------
// jkm_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module jkm_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jkm_pkg::result_t result,
	output logic             ready,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             key_valid,
	output logic [7:0]       key_code
);

	logic       valid_q;
	logic       key_valid_q;
	logic [7:0] key_code_q;

	// free when empty or being taken
	assign ready = !valid_q || !result_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			key_valid_q <= result.key_valid;
			key_code_q  <= result.key_code;
		end
	end

	assign result_valid = valid_q;
	assign key_valid    = key_valid_q;
	assign key_code     = key_code_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_key_message_parser. Byte beats are driven on
// the input channel, and a local parser model predicts the key result of each
// message. Every result beat is compared with the oldest prediction. Directed
// messages come first, then random messages that are mostly well formed with
// some damage mixed in. Both channels idle at random, and one long receiver
// hold makes the block stall its input.
// ----------------------------------------------------------------------------
module tb;
	import jkm_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 120;
	localparam int RANDOM_MSGS    = 4;
	localparam int HOLD_OFF       = 120;
	localparam int DRAIN_CYCLES   = 20;

	// grammar position of the local parser model
	typedef enum logic [3:0] {
		PS_OPEN, PS_MEMBER, PS_NAME, PS_COLON, PS_VALUE, PS_OPVAL,
		PS_SKIP, PS_SIGN, PS_DIGITS, PS_AFTER, PS_TRAIL, PS_FAIL
	} parse_state_e;

	// what one byte inside a string does
	typedef enum logic [1:0] {SB_TEXT, SB_CLOSE, SB_ESCAPE} str_byte_e;

	typedef struct {
		logic       key_ok;
		logic [7:0] code;
	} key_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] text_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       end_without_byte = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       key_valid;
	logic [7:0] key_code;

	// parser model state
	parse_state_e phase;
	logic [3:0]   name_kind;
	logic [2:0]   op_match;
	logic         in_escape;
	logic         code_neg;
	logic [8:0]   code_mag;
	logic         have_code;
	logic         have_op;
	logic         op_says_key;

	key_result_t  expected_keys[$];
	logic [7:0]   msg[$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_wait = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	int input_stall_cycles = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int results_seen = 0;
	int keys_accepted = 0;
	int mismatches = 0;

	json_key_message_parser u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.text_byte        (text_byte),
		.last_byte        (last_byte),
		.end_without_byte (end_without_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.key_valid        (key_valid),
		.key_code         (key_code)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------
	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// member name matcher; a zero byte freezes the match
	function automatic logic [3:0] next_name(input logic [3:0] s, input logic [7:0] c);
		logic [7:0] want;
		logic [3:0] hit;
		if (s >= NM_OTHER)
			return s;
		if (c == CH_NUL)
			return (s == NM_OP) ? NM_OP_DONE : (s == NM_CODE) ? NM_CODE_DONE : NM_OTHER;
		if (s == NM_START && c == CH_LC_C)
			return NM_C;
		case (s)
			NM_START: begin want = CH_LC_O; hit = NM_O;    end
			NM_O:     begin want = CH_LC_P; hit = NM_OP;   end
			NM_C:     begin want = CH_LC_O; hit = NM_CO;   end
			NM_CO:    begin want = CH_LC_D; hit = NM_COD;  end
			NM_COD:   begin want = CH_LC_E; hit = NM_CODE; end
			default:  begin want = CH_NUL;  hit = NM_OTHER; end
		endcase
		return (c == want) ? hit : NM_OTHER;
	endfunction

	// op value matcher against "key"
	function automatic logic [2:0] next_value(input logic [2:0] s, input logic [7:0] c);
		logic [2:0] r;
		r = VM_OTHER;
		if (s >= VM_OTHER) begin
			r = s;
		end else if (c == CH_NUL) begin
			r = (s == VM_KEY) ? VM_KEY_DONE : VM_OTHER;
		end else begin
			case (s)
				VM_START: if (c == CH_LC_K) r = VM_K;
				VM_K:     if (c == CH_LC_E) r = VM_KE;
				VM_KE:    if (c == CH_LC_Y) r = VM_KEY;
				default:  r = VM_OTHER;
			endcase
		end
		return r;
	endfunction

	// backslash makes the following byte plain text
	function automatic str_byte_e classify_str(input logic [7:0] c);
		if (in_escape) begin
			in_escape = 1'b0;
			return SB_TEXT;
		end
		if (c == CH_BSLASH) begin
			in_escape = 1'b1;
			return SB_ESCAPE;
		end
		return (c == CH_QUOTE) ? SB_CLOSE : SB_TEXT;
	endfunction

	function automatic void end_of_value(input logic [7:0] c);
		if (!is_blank(c))
			phase = (c == CH_COMMA) ? PS_MEMBER : (c == CH_RBRACE) ? PS_TRAIL : PS_FAIL;
	endfunction

	function automatic void start_number(input logic [7:0] c);
		if (name_kind == NM_CODE_DONE) begin
			code_mag = c - CH_ZERO;
			have_code = 1'b1;
		end
		phase = PS_DIGITS;
	endfunction

	function automatic void clear_parser();
		phase = PS_OPEN;
		name_kind = NM_START;
		op_match = VM_START;
		in_escape = 1'b0;
		code_neg = 1'b0;
		code_mag = '0;
		have_code = 1'b0;
		have_op = 1'b0;
		op_says_key = 1'b0;
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		str_byte_e k;
		int acc;
		case (phase)
			PS_OPEN: begin
				if (!is_blank(c))
					phase = (c == CH_LBRACE) ? PS_MEMBER : PS_FAIL;
			end
			PS_MEMBER: begin
				if (c == CH_RBRACE) begin
					phase = PS_TRAIL;
				end else if (c == CH_QUOTE) begin
					phase = PS_NAME;
					name_kind = NM_START;
					in_escape = 1'b0;
				end else if (!is_blank(c)) begin
					phase = PS_FAIL;
				end
			end
			PS_NAME: begin
				k = classify_str(c);
				if (k == SB_TEXT) begin
					name_kind = next_name(name_kind, c);
				end else if (k == SB_CLOSE) begin
					if (name_kind == NM_OP || name_kind == NM_OP_DONE)
						name_kind = NM_OP_DONE;
					else if (name_kind == NM_CODE || name_kind == NM_CODE_DONE)
						name_kind = NM_CODE_DONE;
					else
						name_kind = NM_OTHER;
					phase = PS_COLON;
				end
			end
			PS_COLON: begin
				if (!is_blank(c))
					phase = (c == CH_COLON) ? PS_VALUE : PS_FAIL;
			end
			PS_VALUE: begin
				if (is_blank(c)) begin
				end else if (name_kind == NM_OP_DONE) begin
					// op takes a string only
					if (c == CH_QUOTE) begin
						phase = PS_OPVAL;
						op_match = VM_START;
						in_escape = 1'b0;
					end else begin
						phase = PS_FAIL;
					end
				end else begin
					// a new code value replaces the previous one
					if (name_kind == NM_CODE_DONE) begin
						code_neg = 1'b0;
						code_mag = '0;
					end
					if (c == CH_MINUS) begin
						if (name_kind == NM_CODE_DONE)
							code_neg = 1'b1;
						phase = PS_SIGN;
					end else if (is_num(c)) begin
						start_number(c);
					end else if (c == CH_QUOTE && name_kind != NM_CODE_DONE) begin
						phase = PS_SKIP;
						in_escape = 1'b0;
					end else begin
						phase = PS_FAIL;
					end
				end
			end
			PS_OPVAL: begin
				k = classify_str(c);
				if (k == SB_TEXT) begin
					op_match = next_value(op_match, c);
				end else if (k == SB_CLOSE) begin
					have_op = 1'b1;
					op_says_key = (op_match == VM_KEY || op_match == VM_KEY_DONE);
					phase = PS_AFTER;
				end
			end
			PS_SKIP: begin
				if (classify_str(c) == SB_CLOSE)
					phase = PS_AFTER;
			end
			PS_SIGN: begin
				if (is_num(c))
					start_number(c);
				else
					phase = PS_FAIL;
			end
			PS_DIGITS: begin
				if (!is_num(c)) begin
					// the byte that ends a number is handled as a separator
					phase = PS_AFTER;
					end_of_value(c);
				end else if (name_kind == NM_CODE_DONE) begin
					acc = int'(code_mag) * 10 + int'(c - CH_ZERO);
					code_mag = (code_mag >= CODE_SAT || acc > int'(CODE_MAX)) ?
						CODE_SAT : 9'(acc);
				end
			end
			PS_AFTER: end_of_value(c);
			PS_TRAIL: begin
				if (!is_blank(c))
					phase = PS_FAIL;
			end
			default: phase = PS_FAIL;
		endcase
	endfunction

	// one accepted beat; an ending beat yields the key result
	function automatic void step_key_parser(input logic [7:0] c, input logic last,
			input logic bare);
		key_result_t r;
		if (!bare)
			parse_byte(c);
		if (last || bare) begin
			r.key_ok = phase == PS_TRAIL && have_code && (!have_op || op_says_key)
				&& code_mag <= CODE_MAX && !(code_neg && code_mag != 0);
			r.code = r.key_ok ? code_mag[7:0] : 8'h00;
			expected_keys.push_back(r);
			clear_parser();
		end
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] c, input logic last, input logic bare);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		text_byte <= c;
		last_byte <= last;
		end_without_byte <= bare;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		step_key_parser(c, last, bare);
		items_sent++;
	endtask

	// sends the bytes in msg; an empty text always ends with a bare beat
	task automatic send_message(input bit bare_end);
		for (int i = 0; i < msg.size(); i++)
			send_beat(msg[i], !bare_end && i == msg.size() - 1, 1'b0);
		if (bare_end || msg.size() == 0)
			send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		messages_sent++;
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endfunction

	task automatic send_text(input string s, input bit bare_end = 1'b0);
		msg.delete();
		add_text(s);
		send_message(bare_end);
	endtask

	// text with a zero byte between the two parts
	task automatic send_nul_split(input string head, input string tail);
		msg.delete();
		add_text(head);
		msg.push_back(CH_NUL);
		add_text(tail);
		send_message(1'b0);
	endtask

	// ------------------------------------------------------------------------
	// random message pieces
	// ------------------------------------------------------------------------
	function automatic void add_blank();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				msg.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
					8'(CH_TAB + $urandom_range(0, 4)));
	endfunction

	function automatic void add_random_body(input int max_len);
		logic [7:0] c;
		repeat ($urandom_range(0, max_len)) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 7) == 0)
				msg.push_back(CH_BSLASH);
			msg.push_back(c);
		end
	endfunction

	function automatic void add_number();
		if ($urandom_range(0, 7) == 0) begin
			msg.push_back(CH_MINUS);
			if ($urandom_range(0, 1) == 0) begin
				msg.push_back(CH_ZERO);
				return;
			end
		end
		case ($urandom_range(0, 7))
			0: msg.push_back(CH_ZERO);
			1: add_text($sformatf("%0d", $urandom_range(256, 99999)));
			2: begin
				repeat ($urandom_range(1, 3)) msg.push_back(CH_ZERO);
				add_text($sformatf("%0d", $urandom_range(0, 255)));
			end
			3: repeat ($urandom_range(10, 14)) msg.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			default: add_text($sformatf("%0d", $urandom_range(0, 255)));
		endcase
	endfunction

	function automatic void add_op_value();
		msg.push_back(CH_QUOTE);
		case ($urandom_range(0, 5))
			0, 1, 2: add_text("key");
			3: begin
				add_text("key");
				msg.push_back(CH_NUL);
				add_random_body(3);
			end
			4: add_text("k\\ey");
			default: add_random_body(4);
		endcase
		msg.push_back(CH_QUOTE);
	endfunction

	function automatic void add_string_value();
		msg.push_back(CH_QUOTE);
		add_random_body(6);
		msg.push_back(CH_QUOTE);
	endfunction

	function automatic void add_member();
		int pick;
		pick = $urandom_range(0, 9);
		msg.push_back(CH_QUOTE);
		if (pick < 5) begin
			add_text("code");
		end else if (pick < 7) begin
			add_text("op");
		end else if (pick == 7) begin
			add_random_body(5);
		end else begin
			// names that nearly match
			case ($urandom_range(0, 4))
				0: add_text("c\\ode");
				1: begin
					add_text("code");
					msg.push_back(CH_NUL);
					add_random_body(2);
				end
				2: begin
					add_text("op");
					msg.push_back(CH_NUL);
				end
				3: add_text("cod");
				default: add_text("opx");
			endcase
		end
		msg.push_back(CH_QUOTE);
		add_blank();
		msg.push_back(CH_COLON);
		add_blank();
		if (pick < 5) begin
			if ($urandom_range(0, 9) == 0) add_string_value(); else add_number();
		end else if (pick < 7) begin
			if ($urandom_range(0, 9) == 0) add_number(); else add_op_value();
		end else begin
			case ($urandom_range(0, 2))
				0: add_number();
				1: add_op_value();
				default: add_string_value();
			endcase
		end
	endfunction

	function automatic void build_random_message();
		int members;
		bit trailing;
		msg.delete();
		members = $urandom_range(0, 4);
		trailing = $urandom_range(0, 4) == 0;
		add_blank();
		msg.push_back(CH_LBRACE);
		for (int i = 0; i < members; i++) begin
			add_blank();
			add_member();
			add_blank();
			if (i < members - 1 || trailing)
				msg.push_back(CH_COMMA);
		end
		msg.push_back(CH_RBRACE);
		add_blank();
		// occasional damage
		case ($urandom_range(0, 11))
			0: repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
			1: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
			2: msg.push_back(8'($urandom_range(0, 255)));
			3: if ($urandom_range(0, 3) == 0) msg.delete();
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------
	// receiver stall: a long hold when asked, else the drawn wait per result
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			result_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		key_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
			if (expected_keys.size() == 0) begin
				$error("unexpected result beat: key_valid %0b key_code %0d",
					key_valid, key_code);
				mismatches++;
			end else begin
				want = expected_keys.pop_front();
				if (want.key_ok)
					keys_accepted++;
				if (key_valid !== want.key_ok) begin
					$error("key_valid mismatch: expected %0b, actual %0b",
						want.key_ok, key_valid);
					mismatches++;
				end
				if (key_code !== want.code) begin
					$error("key_code mismatch: expected %0d, actual %0d",
						want.code, key_code);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (item_valid && item_stall)
			input_stall_cycles++;
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_well_formed();
		send_text("{\"code\":7}");
		// every whitespace byte around and inside the object
		msg.delete();
		for (logic [7:0] w = CH_TAB; w <= CH_CR; w++)
			msg.push_back(w);
		msg.push_back(CH_SPACE);
		add_text("{ \"op\"\t: \"key\" ,\n\"code\" :255 , }");
		msg.push_back(CH_SPACE);
		msg.push_back(8'h0B);
		send_message(1'b0);
		send_text("{}");
		send_text("{\"code\":0,\"op\":\"kez\"}");
	endtask

	task automatic test_code_values();
		send_text("{\"code\":-0}");
		send_text("{\"code\":-3}");
		send_text("{\"code\":256}");
		send_text("{\"code\":00000255}");
		send_text("{\"code\":99999999999}");
		send_text("{\"code\":300,\"code\":9}");
		send_text("{\"code\":-5,\"code\":5}");
		send_text("{\"code\":\"5\"}");
		send_text("{\"code\":1 2}");
		send_text("{\"code\":-}");
	endtask

	task automatic test_string_matching();
		send_text("{\"c\\ode\":4}");
		send_nul_split("{\"code", "zz\":9}");
		send_nul_split("{\"co", "de\":9}");
		send_nul_split("{\"op\":\"key", "junk\",\"code\":1}");
		send_text("{\"op\":\"ke\\y\",\"code\":2}");
		send_text("{\"op\":\"keyx\",\"code\":2}");
		send_text("{\"op\":\"no\",\"op\":\"key\",\"code\":3}");
		send_text("{\"x\\\"y\":\"a\\\\\\\"b\",\"n\":-12,\"code\":8}");
		send_text("{\"op\":5,\"code\":1}");
		// high bytes in a member name
		msg.delete();
		add_text("{\"");
		msg.push_back(8'hFF);
		msg.push_back(8'h80);
		add_text("\":1,\"code\":200}");
		send_message(1'b0);
	endtask

	task automatic test_malformed();
		send_text("{\"code\":5");
		send_text("{\"code\":5", 1'b1);
		send_text("{\"code\":5} x");
		send_text("{\"code\":5}  ", 1'b1);
		send_text("");
		send_text("x{\"code\":1}");
		send_text("{,}");
		send_text("{\"code\":1,,}");
		send_text("{\"code\" 1}");
	endtask

	// long receiver hold while back-to-back messages keep coming
	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		@(negedge clk);
		item_valid <= 1'b0;
		hold_cycles = HOLD_OFF;
		for (int i = 0; i < 4; i++)
			send_text($sformatf("{\"code\":%0d}", 40 + i));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_random_messages();
		int first_item;
		int count;
		first_item = items_sent;
		count = 0;
		while (items_sent - first_item < RANDOM_BYTES || count < RANDOM_MSGS) begin
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			build_random_message();
			send_message($urandom_range(0, 9) == 0);
			count++;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_well_formed();
		test_code_values();
		test_string_matching();
		test_malformed();
		test_output_backpressure();
		test_random_messages();

		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d byte beats in %0d messages, %0d results, %0d keys accepted",
			items_sent, messages_sent, results_seen, keys_accepted);
		$display("summary: input held off for %0d cycles by output backpressure",
			input_stall_cycles);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
